### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/eap_pkg.sv
// ----------------------------------------------------------------------------
// eap_pkg
// Types, constants and helper functions for the encoder angle PID block.
// ----------------------------------------------------------------------------
package eap_pkg;

   localparam int DIVIDEND_W = 35;
   localparam int DIVISOR_W  = 24;
   localparam int GAIN_W     = 16;
   localparam int OPND_W     = 33;
   localparam int PROD_W     = 49;
   localparam int SUM_W      = 51;

   localparam logic [1:0] REG_GAIN_PROP  = 2'd0;
   localparam logic [1:0] REG_GAIN_INTEG = 2'd1;
   localparam logic [1:0] REG_GAIN_DERIV = 2'd2;
   localparam logic [1:0] REG_CPR        = 2'd3;

   localparam logic signed [OPND_W-1:0] ERR_LIMIT   = 33'sd300;
   localparam logic signed [OPND_W-1:0] INTEG_LIMIT = 33'sd100;
   localparam logic signed [OPND_W-1:0] DIFF_LIMIT  = 33'sd1000;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic              start;
      logic [GAIN_W-1:0] gain;
      logic [OPND_W-1:0] operand;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

   function automatic logic signed [OPND_W-1:0] clamp33(
      input logic signed [OPND_W-1:0] x,
      input logic signed [OPND_W-1:0] lim);
      logic signed [OPND_W-1:0] r;
      if (x > lim) begin
         r = lim;
      end else if (x < -lim) begin
         r = -lim;
      end else begin
         r = x;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
      logic signed [31:0] r;
      if (x > $signed({{(SUM_W-32){1'b0}}, 32'h7fff_ffff})) begin
         r = 32'sh7fff_ffff;
      end else if (x < $signed({{(SUM_W-32){1'b1}}, 32'h8000_0000})) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/eap_div.sv
// ----------------------------------------------------------------------------
// eap_div
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eap_div (
   input  logic                 clock,
   input  logic                 reset,
   input  eap_pkg::div_req_type req,
   output eap_pkg::div_rsp_type rsp
);

   logic [eap_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [eap_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [eap_pkg::DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [5:0]                     cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [eap_pkg::DIVISOR_W:0]    trial;
   logic [eap_pkg::DIVISOR_W+1:0]  sub;

   assign trial = {rem_ff, quo_ff[eap_pkg::DIVIDEND_W-1]};
   assign sub   = {1'b0, trial} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = 6'(eap_pkg::DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!sub[eap_pkg::DIVISOR_W+1]) begin
            rem_in = sub[eap_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[eap_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[eap_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[eap_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

### rtl/eap_mul.sv
// ----------------------------------------------------------------------------
// eap_mul
// Shift-add multiplier of an unsigned gain by a signed operand, one gain bit
// per cycle.
// ----------------------------------------------------------------------------
module eap_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  eap_pkg::mul_req_type req,
   output eap_pkg::mul_rsp_type rsp
);

   logic [eap_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic [eap_pkg::PROD_W-1:0] mcand_ff, mcand_in;
   logic [eap_pkg::GAIN_W-1:0] mplr_ff, mplr_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         acc_in   = '0;
         mcand_in = {{(eap_pkg::PROD_W-eap_pkg::OPND_W){req.operand[eap_pkg::OPND_W-1]}},
                     req.operand};
         mplr_in  = req.gain;
         cnt_in   = 5'(eap_pkg::GAIN_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (mplr_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = {mcand_ff[eap_pkg::PROD_W-2:0], 1'b0};
         mplr_in  = {1'b0, mplr_ff[eap_pkg::GAIN_W-1:1]};
         cnt_in   = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

### rtl/encoder_angle_pid.sv
// ----------------------------------------------------------------------------
// encoder_angle_pid
// Per-channel PID position controller driven by encoder count words.
// ----------------------------------------------------------------------------
// Each request word carries a channel, the encoder count since the last tick
// and a target angle. The block updates that channel's position, converts it
// to an angle with a bit-serial divider, forms the error, updates the
// integral and derivative state and builds the drive with a bit-serial
// multiplier used three times. One response word follows each request.
// A word passes through states that start the divider, wait for its 35-bit
// quotient, scale the quotient, form the error, update the PID state, run
// the multiplier once per gain and load the output register. The position
// is updated at the accepting edge. A new request is taken in the cycle
// after the previous one has reached the output register.
// req_stall is high while a word is in work. If rsp_stall holds a response,
// the next word still runs and waits at the end until the output register
// frees up. Reset clears all channel state, restores the default gains and
// empties the output register. Gains and counts per revolution are to be
// written over the register port only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module encoder_angle_pid #(
   parameter int CHANNELS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_channel,
   input  logic signed [15:0] req_count_delta,
   input  logic signed [23:0] req_target_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_channel,
   output logic signed [31:0] rsp_drive,
   output logic signed [31:0] rsp_angle_error,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

`include "assert_macros.svh"

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_ERR   = 3'd3;
   localparam logic [2:0] ST_UPD   = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;
   localparam logic [2:0] ST_SCALE = 3'd7;

   logic [15:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic [23:0] cpr_ff;

   logic [31:0]        position_ff [CHANNELS];
   logic signed [31:0] integral_ff [CHANNELS];
   logic signed [31:0] prev_err_ff [CHANNELS];

   logic [2:0]          state_ff, state_in;
   logic [CH_W-1:0]     ch_ff;
   logic [1:0]          chan_ff;
   logic signed [23:0]  target_ff;
   logic                neg_ff;
   logic [40:0]         qmag_ff;
   logic signed [31:0]  err_ff;
   logic signed [7:0]   ci_ff;
   logic signed [10:0]  diff_ff;
   logic [1:0]          phase_ff;
   logic signed [eap_pkg::SUM_W-1:0] sum_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_chan_ff;
   logic signed [31:0] rsp_drive_ff, rsp_err_ff;

   logic                req_acc, rsp_acc, cfg_wr;
   logic [4:0]          ch_mod;
   logic [CH_W-1:0]     ch_idx;
   logic [31:0]         pos_cur;
   logic signed [35:0]  p10;
   logic [35:0]         p10_mag;
   logic [34:0]         q;
   logic signed [42:0]  err64;
   logic signed [32:0]  integ_sum, diff_raw, clamp_e, clamp_i, clamp_d;
   logic signed [31:0]  integ_new;
   logic [1:0]          mphase;
   logic signed [eap_pkg::SUM_W-1:0] prod_ext;
   logic                out_free;

   eap_pkg::div_req_type div_req;
   eap_pkg::div_rsp_type div_rsp;
   eap_pkg::mul_req_type mul_req;
   eap_pkg::mul_rsp_type mul_rsp;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid_ff && !rsp_stall;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   always_comb begin
      ch_mod = {3'd0, req_channel};
      for (int k = 0; k < 3; k++) begin
         if (ch_mod >= 5'(CHANNELS)) begin
            ch_mod = ch_mod - 5'(CHANNELS);
         end
      end
   end

   assign ch_idx = CH_W'(ch_mod);

   always_comb begin
      case (paddr[3:2])
         eap_pkg::REG_GAIN_PROP:  prdata = {16'd0, gain_prop_ff};
         eap_pkg::REG_GAIN_INTEG: prdata = {16'd0, gain_integ_ff};
         eap_pkg::REG_GAIN_DERIV: prdata = {16'd0, gain_deriv_ff};
         eap_pkg::REG_CPR:        prdata = {8'd0, cpr_ff};
         default:                 prdata = '0;
      endcase
   end

   assign pos_cur = position_ff[ch_ff];
   assign p10     = ($signed({{4{pos_cur[31]}}, pos_cur}) <<< 3)
                  + ($signed({{4{pos_cur[31]}}, pos_cur}) <<< 1);
   assign p10_mag = pos_cur[31] ? 36'(-p10) : 36'(p10);

   assign q     = (cpr_ff == 24'd0) ? 35'd0 : div_rsp.quotient;
   assign err64 = neg_ff ? (43'(target_ff) + $signed({2'b00, qmag_ff}))
                         : (43'(target_ff) - $signed({2'b00, qmag_ff}));

   assign clamp_e   = eap_pkg::clamp33(33'(err_ff), eap_pkg::ERR_LIMIT);
   assign integ_sum = 33'(integral_ff[ch_ff]) + clamp_e;
   assign integ_new = eap_pkg::sat32(eap_pkg::SUM_W'(integ_sum));
   assign clamp_i   = eap_pkg::clamp33(33'(integ_new), eap_pkg::INTEG_LIMIT);
   assign diff_raw  = 33'(err_ff) - 33'(prev_err_ff[ch_ff]);
   assign clamp_d   = eap_pkg::clamp33(diff_raw, eap_pkg::DIFF_LIMIT);

   assign div_req.start    = (state_ff == ST_PREP);
   assign div_req.dividend = p10_mag[34:0];
   assign div_req.divisor  = cpr_ff;

   assign mphase = (state_ff == ST_UPD) ? 2'd0 : phase_ff + 2'd1;

   always_comb begin
      mul_req.start = (state_ff == ST_UPD)
                   || (state_ff == ST_MUL && mul_rsp.done && phase_ff != 2'd2);
      case (mphase)
         2'd0: begin
            mul_req.gain    = gain_prop_ff;
            mul_req.operand = 33'(err_ff);
         end
         2'd1: begin
            mul_req.gain    = gain_integ_ff;
            mul_req.operand = 33'(ci_ff);
         end
         2'd2: begin
            mul_req.gain    = gain_deriv_ff;
            mul_req.operand = 33'(diff_ff);
         end
         default: begin
            mul_req.gain    = '0;
            mul_req.operand = '0;
         end
      endcase
   end

   assign prod_ext = eap_pkg::SUM_W'($signed(mul_rsp.product));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc) state_in = ST_PREP;
         ST_PREP:  state_in = ST_DIV;
         ST_DIV:   if (div_rsp.done) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ERR;
         ST_ERR:   state_in = ST_UPD;
         ST_UPD:   state_in = ST_MUL;
         ST_MUL:   if (mul_rsp.done && phase_ff == 2'd2) state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         gain_prop_ff  <= 16'd9011;
         gain_integ_ff <= 16'd410;
         gain_deriv_ff <= 16'd0;
         cpr_ff        <= 24'd98588;
         for (int i = 0; i < CHANNELS; i++) begin
            position_ff[i] <= '0;
            integral_ff[i] <= '0;
            prev_err_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            case (paddr[3:2])
               eap_pkg::REG_GAIN_PROP:  gain_prop_ff  <= pwdata[15:0];
               eap_pkg::REG_GAIN_INTEG: gain_integ_ff <= pwdata[15:0];
               eap_pkg::REG_GAIN_DERIV: gain_deriv_ff <= pwdata[15:0];
               eap_pkg::REG_CPR:        cpr_ff        <= pwdata[23:0];
               default: ;
            endcase
         end
         if (req_acc) begin
            position_ff[ch_idx] <= position_ff[ch_idx] - 32'(req_count_delta);
         end
         if (state_ff == ST_UPD) begin
            integral_ff[ch_ff] <= integ_new;
            prev_err_ff[ch_ff] <= err_ff;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_acc) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         ch_ff     <= ch_idx;
         chan_ff   <= req_channel;
         target_ff <= req_target_angle;
      end
      if (state_ff == ST_PREP) begin
         neg_ff <= pos_cur[31];
      end
      if (state_ff == ST_SCALE) begin
         qmag_ff <= ({6'd0, q} << 5) + ({6'd0, q} << 2);
      end
      if (state_ff == ST_ERR) begin
         err_ff <= eap_pkg::sat32(eap_pkg::SUM_W'(err64));
      end
      if (state_ff == ST_UPD) begin
         ci_ff   <= clamp_i[7:0];
         diff_ff <= clamp_d[10:0];
         sum_ff  <= '0;
      end
      if (mul_req.start) begin
         phase_ff <= mphase;
      end
      if (state_ff == ST_MUL && mul_rsp.done) begin
         if (phase_ff == 2'd2) begin
            sum_ff <= sum_ff - prod_ext;
         end else begin
            sum_ff <= sum_ff + prod_ext;
         end
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_chan_ff  <= chan_ff;
         rsp_drive_ff <= eap_pkg::sat32(sum_ff >>> 12);
         rsp_err_ff   <= err_ff;
      end
   end

   eap_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   eap_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_drive       = rsp_drive_ff;
   assign rsp_angle_error = rsp_err_ff;

   `ASSERT_NXT(a_acc_prep, clock, reset, req_acc, state_ff == ST_PREP, "accept did not start")
   `ASSERT_IMP(a_div_done, clock, reset, div_rsp.done, state_ff == ST_DIV, "stray divide done")
   `ASSERT_IMP(a_mul_done, clock, reset, mul_rsp.done, state_ff == ST_MUL, "stray multiply done")

endmodule
